// File: src/crec_pkg.sv
// Shared constants, state codes and the arctangent table for the edge crossing core.
package crec_pkg;

   localparam int MaxHits = 8;
   localparam int CordicSteps = 24;
   localparam logic [31:0] ThresholdReset = 32'd6554;
   localparam logic [31:0] HalfTurn = 32'h8000_0000;
   localparam logic [29:0] RootTopBit = 30'h1000_0000;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SETUP = 4'd1;
   localparam logic [3:0] S_RR    = 4'd2;
   localparam logic [3:0] S_OO    = 4'd3;
   localparam logic [3:0] S_LL    = 4'd4;
   localparam logic [3:0] S_DISC  = 4'd5;
   localparam logic [3:0] S_SQRT  = 4'd6;
   localparam logic [3:0] S_ROUND = 4'd7;
   localparam logic [3:0] S_PT    = 4'd8;
   localparam logic [3:0] S_CORD  = 4'd9;
   localparam logic [3:0] S_INS   = 4'd10;
   localparam logic [3:0] S_NEXT  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   localparam logic [1:0] EDGE_TOP    = 2'd0;
   localparam logic [1:0] EDGE_RIGHT  = 2'd1;
   localparam logic [1:0] EDGE_BOTTOM = 2'd2;
   localparam logic [1:0] EDGE_LEFT   = 2'd3;

   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0: v = 32'd536870912;
         5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;
         5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;
         5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;
         5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;
         5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// File: src/circle_rect_edge_crossings_core.sv
// Circle and rectangle edge crossing core: finds, tags and angle-sorts the crossing points.
//
// One request beat carries a rectangle and a circle; the core answers with up to eight
// response beats, one per crossing sorted by angle about the center, or a single beat
// flagged in tuser when there is none, with tlast on the final beat. The core takes one
// request at a time and holds req_tready low while it works. An edge of zero length is
// skipped. Otherwise the core squares the radius, the offset and the length on the shared
// 32x32 multiplier, drops the edge when the circle misses its line, and uses the multiplier
// again for the discriminant test; an edge that passes it runs the bit-serial square root
// and a rounding step, then the segment test for each candidate point, and CORDIC and
// sorted insertion for each point that is kept. A new request is taken while the last
// response beat still waits on rsp_tready.
module circle_rect_edge_crossings_core
   import crec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rect_left, rect_top, rect_right, rect_bottom, center_x, center_y, circle_size, pad
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // cross_x, cross_y, cross_angle, entering, pad
   output logic [55:0]  rsp_tdata,
   // none_found
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   logic [3:0]         state_ff, state_in;
   logic [31:0]        thr_ff;
   logic signed [15:0] left_ff, top_ff, right_ff, bottom_ff, cx_ff, cy_ff;
   logic [14:0]        rad_ff;
   logic [1:0]         edge_ff, edge_in;
   logic [29:0]        rr_ff, rr_in;
   logic signed [34:0] q_ff, q_in;
   logic [31:0]        len2_ff, len2_in;
   logic [29:0]        rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [15:0]        s_ff, s_in;
   logic               pt_ff, pt_in;
   logic signed [47:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [31:0]        acc_ff, acc_in;
   logic [4:0]         step_ff, step_in;
   logic [15:0]        hx_ff, hx_in, hy_ff, hy_in;
   logic               hin_ff, hin_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [2:0]         oidx_ff, oidx_in;
   logic [15:0]        ex_ff [MaxHits], ex_in [MaxHits];
   logic [15:0]        ey_ff [MaxHits], ey_in [MaxHits];
   logic [16:0]        ea_ff [MaxHits], ea_in [MaxHits];
   logic               ee_ff [MaxHits], ee_in [MaxHits];
   logic               rv_ff, rv_in, ru_ff, ru_in, rl_ff, rl_in;
   logic [49:0]        rd_ff, rd_in;

   logic signed [16:0] ax, ay, bx, by, dd, off;
   logic               horiz;
   logic [15:0]        len, off_abs;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        prod;
   logic [29:0]        trial;
   logic signed [19:0] sdv, base, pp, sa, sb, vx0, vy0, hxw, hyw;
   logic               on_seg;
   logic signed [47:0] tx, ty;
   logic [31:0]        acc_rnd;
   logic [16:0]        ang_new;
   logic [3:0]         kpos;

   function automatic logic [15:0] sat16(input logic signed [19:0] v);
      logic [15:0] r;
      if (v > 20'sd32767) begin
         r = 16'h7fff;
      end else if (v < -20'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   always_comb begin
      ax = '0;
      ay = '0;
      bx = '0;
      by = '0;
      horiz = 1'b1;
      case (edge_ff)
         EDGE_TOP: begin
            ax = {left_ff[15], left_ff};   ay = {top_ff[15], top_ff};
            bx = {right_ff[15], right_ff}; by = {top_ff[15], top_ff};
            horiz = 1'b1;
         end
         EDGE_RIGHT: begin
            ax = {right_ff[15], right_ff}; ay = {top_ff[15], top_ff};
            bx = {right_ff[15], right_ff}; by = {bottom_ff[15], bottom_ff};
            horiz = 1'b0;
         end
         EDGE_BOTTOM: begin
            ax = {right_ff[15], right_ff}; ay = {bottom_ff[15], bottom_ff};
            bx = {left_ff[15], left_ff};   by = {bottom_ff[15], bottom_ff};
            horiz = 1'b1;
         end
         EDGE_LEFT: begin
            ax = {left_ff[15], left_ff};   ay = {bottom_ff[15], bottom_ff};
            bx = {left_ff[15], left_ff};   by = {top_ff[15], top_ff};
            horiz = 1'b0;
         end
         default: begin
            horiz = 1'b1;
         end
      endcase
      dd = horiz ? (bx - ax) : (by - ay);
      off = horiz ? (ay - {cy_ff[15], cy_ff}) : (ax - {cx_ff[15], cx_ff});
      len = dd[16] ? 16'((-dd)) : dd[15:0];
      off_abs = off[16] ? 16'((-off)) : off[15:0];

      case (state_ff)
         S_RR: begin
            mul_a = {17'd0, rad_ff};
            mul_b = {17'd0, rad_ff};
         end
         S_OO: begin
            mul_a = {16'd0, off_abs};
            mul_b = {16'd0, off_abs};
         end
         S_LL: begin
            mul_a = {16'd0, len};
            mul_b = {16'd0, len};
         end
         S_DISC: begin
            mul_a = len2_ff;
            mul_b = {2'd0, q_ff[29:0]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = {32'd0, mul_a} * {32'd0, mul_b};

      trial = res_ff + bit_ff;

      sdv = (horiz && dd <= 17'sd0) ? -$signed({4'd0, s_ff}) : $signed({4'd0, s_ff});
      base = horiz ? 20'(cx_ff) : 20'(cy_ff);
      pp = pt_ff ? (base - sdv) : (base + sdv);
      sa = horiz ? 20'(ax) : 20'(ay);
      sb = horiz ? 20'(bx) : 20'(by);
      on_seg = (sb > sa) ? (sa <= pp && pp <= sb) : (sb <= pp && pp <= sa);
      if (horiz) begin
         vx0 = pt_ff ? -sdv : sdv;
         vy0 = 20'(off);
         hxw = pp;
         hyw = 20'(ay);
      end else begin
         vx0 = 20'(off);
         vy0 = pt_ff ? -sdv : sdv;
         hxw = 20'(ax);
         hyw = pp;
      end

      tx = vx_ff >>> step_ff;
      ty = vy_ff >>> step_ff;

      acc_rnd = acc_ff + 32'h0000_8000;
      ang_new = (acc_rnd[31:16] == 16'd0) ? 17'h10000 : {1'b0, acc_rnd[31:16]};
      kpos = '0;
      for (int i = 0; i < MaxHits; i++) begin
         if (4'(i) < cnt_ff && ea_ff[i] <= ang_new) begin
            kpos = kpos + 4'd1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      edge_in = edge_ff;
      rr_in = rr_ff;
      q_in = q_ff;
      len2_in = len2_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      s_in = s_ff;
      pt_in = pt_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      acc_in = acc_ff;
      step_in = step_ff;
      hx_in = hx_ff;
      hy_in = hy_ff;
      hin_in = hin_ff;
      cnt_in = cnt_ff;
      oidx_in = oidx_ff;
      rv_in = rv_ff && !rsp_tready;
      ru_in = ru_ff;
      rl_in = rl_ff;
      rd_in = rd_ff;
      for (int i = 0; i < MaxHits; i++) begin
         ex_in[i] = ex_ff[i];
         ey_in[i] = ey_ff[i];
         ea_in[i] = ea_ff[i];
         ee_in[i] = ee_ff[i];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_SETUP;
               edge_in = EDGE_TOP;
               cnt_in = '0;
            end
         end
         S_SETUP: begin
            state_in = (dd == 17'sd0) ? S_NEXT : S_RR;
         end
         S_RR: begin
            rr_in = prod[29:0];
            state_in = S_OO;
         end
         S_OO: begin
            q_in = $signed({5'd0, rr_ff}) - $signed({1'b0, prod[33:0]});
            state_in = S_LL;
         end
         S_LL: begin
            len2_in = prod[31:0];
            state_in = q_ff[34] ? S_NEXT : S_DISC;
         end
         S_DISC: begin
            rem_in = q_ff[29:0];
            res_in = '0;
            bit_in = RootTopBit;
            state_in = (prod < {32'd0, thr_ff}) ? S_NEXT : S_SQRT;
         end
         S_SQRT: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 30'd1) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            s_in = (rem_ff > res_ff) ? 16'(res_ff + 30'd1) : res_ff[15:0];
            pt_in = 1'b0;
            state_in = S_PT;
         end
         S_PT: begin
            if (on_seg) begin
               hx_in = sat16(hxw);
               hy_in = sat16(hyw);
               hin_in = (edge_ff == EDGE_LEFT) ^ !pt_ff;
               step_in = '0;
               if (vx0 == 20'sd0 && vy0 == 20'sd0) begin
                  acc_in = HalfTurn;
                  state_in = S_INS;
               end else begin
                  if (vx0 < 20'sd0) begin
                     vx_in = 48'(-vx0) <<< 24;
                     vy_in = 48'(-vy0) <<< 24;
                     acc_in = HalfTurn;
                  end else begin
                     vx_in = 48'(vx0) <<< 24;
                     vy_in = 48'(vy0) <<< 24;
                     acc_in = '0;
                  end
                  state_in = S_CORD;
               end
            end else if (!pt_ff) begin
               pt_in = 1'b1;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_CORD: begin
            if (vy_ff > 48'sd0) begin
               vx_in = vx_ff + ty;
               vy_in = vy_ff - tx;
               acc_in = acc_ff + atan_turn(step_ff);
            end else begin
               vx_in = vx_ff - ty;
               vy_in = vy_ff + tx;
               acc_in = acc_ff - atan_turn(step_ff);
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(CordicSteps - 1)) begin
               state_in = S_INS;
            end
         end
         S_INS: begin
            if (cnt_ff < 4'(MaxHits)) begin
               for (int i = 0; i < MaxHits; i++) begin
                  if (4'(i) == kpos) begin
                     ex_in[i] = hx_ff;
                     ey_in[i] = hy_ff;
                     ea_in[i] = ang_new;
                     ee_in[i] = hin_ff;
                  end else if (i > 0 && 4'(i) > kpos) begin
                     ex_in[i] = ex_ff[i-1];
                     ey_in[i] = ey_ff[i-1];
                     ea_in[i] = ea_ff[i-1];
                     ee_in[i] = ee_ff[i-1];
                  end
               end
               cnt_in = cnt_ff + 4'd1;
            end
            if (!pt_ff) begin
               pt_in = 1'b1;
               state_in = S_PT;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (edge_ff == EDGE_LEFT) begin
               oidx_in = '0;
               state_in = S_OUT;
            end else begin
               edge_in = edge_ff + 2'd1;
               state_in = S_SETUP;
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               if (cnt_ff == 4'd0) begin
                  ru_in = 1'b1;
                  rl_in = 1'b1;
                  rd_in = '0;
                  state_in = S_IDLE;
               end else begin
                  ru_in = 1'b0;
                  rl_in = ({1'b0, oidx_ff} == cnt_ff - 4'd1);
                  rd_in = {ee_ff[oidx_ff], ea_ff[oidx_ff], ey_ff[oidx_ff], ex_ff[oidx_ff]};
                  oidx_in = oidx_ff + 3'd1;
                  if ({1'b0, oidx_ff} == cnt_ff - 4'd1) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         thr_ff <= ThresholdReset;
         rv_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         cnt_ff <= cnt_in;
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         left_ff <= req_tdata[15:0];
         top_ff <= req_tdata[31:16];
         right_ff <= req_tdata[47:32];
         bottom_ff <= req_tdata[63:48];
         cx_ff <= req_tdata[79:64];
         cy_ff <= req_tdata[95:80];
         rad_ff <= req_tdata[110:96];
      end
      edge_ff <= edge_in;
      rr_ff <= rr_in;
      q_ff <= q_in;
      len2_ff <= len2_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      s_ff <= s_in;
      pt_ff <= pt_in;
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      acc_ff <= acc_in;
      step_ff <= step_in;
      hx_ff <= hx_in;
      hy_ff <= hy_in;
      hin_ff <= hin_in;
      oidx_ff <= oidx_in;
      ru_ff <= ru_in;
      rl_ff <= rl_in;
      rd_ff <= rd_in;
      for (int i = 0; i < MaxHits; i++) begin
         ex_ff[i] <= ex_in[i];
         ey_ff[i] <= ey_in[i];
         ea_ff[i] <= ea_in[i];
         ee_ff[i] <= ee_in[i];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {6'd0, rd_ff};
   assign rsp_tuser = ru_ff;
   assign rsp_tlast = rl_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'(MaxHits))
      else $error("hit count exceeds list size");
   a_none_beat: assert property (@(posedge clock) disable iff (reset)
      rv_ff && ru_ff |-> rl_ff && rd_ff == 50'd0)
      else $error("empty response beat not last or not zero");
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_SETUP && cnt_ff == 4'd0 && edge_ff == EDGE_TOP)
      else $error("request did not start a fresh edge walk");
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && cnt_ff >= 4'd2 |-> ea_ff[0] <= ea_ff[1])
      else $error("hit list not sorted by angle");
`endif

endmodule
